[rtl/srsc_pkg.sv]
`default_nettype none

package srsc_pkg;

	// Event codes
	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_TICK    = 3'd1;
	localparam logic [2:0] ACT_KEY     = 3'd2;
	localparam logic [2:0] ACT_TRIGGER = 3'd3;
	localparam logic [2:0] ACT_TIMEOUT = 3'd4;

	// Key codes
	localparam logic [2:0] KEY_S1_PRESS  = 3'd0;
	localparam logic [2:0] KEY_S1_REPEAT = 3'd1;
	localparam logic [2:0] KEY_S2_PRESS  = 3'd2;
	localparam logic [2:0] KEY_S2_REPEAT = 3'd3;
	localparam logic [2:0] KEY_S3_PRESS  = 3'd4;

	// Trigger lines
	localparam logic [1:0] LINE_FIRST  = 2'd0;
	localparam logic [1:0] LINE_SECOND = 2'd1;

	// Modes
	localparam logic [1:0] MODE_OPER  = 2'd0;
	localparam logic [1:0] MODE_POS1  = 2'd1;
	localparam logic [1:0] MODE_POS2  = 2'd2;
	localparam logic [1:0] MODE_SPEED = 2'd3;

	// Config register indexes
	localparam logic [2:0] CFG_STORED_VALID  = 3'd0;
	localparam logic [2:0] CFG_STORED_FIRST  = 3'd1;
	localparam logic [2:0] CFG_STORED_SECOND = 3'd2;
	localparam logic [2:0] CFG_STORED_SPEED  = 3'd3;
	localparam logic [2:0] CFG_PULSE_MIN     = 3'd4;
	localparam logic [2:0] CFG_PULSE_MAX     = 3'd5;
	localparam logic [2:0] CFG_DEFAULT_SPEED = 3'd6;
	localparam logic [2:0] CFG_STOP_TICKS    = 3'd7;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Ramp constants
	localparam logic signed [7:0] SOFT_FULL = 8'sd100;
	localparam logic signed [7:0] SOFT_INIT = -8'sd2;
	localparam logic [7:0]        STOP_TICKS_VALID = 8'd50;
	localparam logic [8:0]        SPEED_MAX = 9'd256;
	localparam logic [8:0]        SPEED_MIN = 9'd1;
	localparam logic [3:0]        TICK_MASK = 4'hF;

	// floor(x/100) = (x * 83887) >> 23, exact for x below 2^16 scaled values used here
	localparam logic [16:0] RECIP_100  = 17'd83887;
	localparam int          RECIP_SHIFT = 23;

	typedef struct packed {
		logic        stored_valid;
		logic [15:0] stored_first_position;
		logic [15:0] stored_second_position;
		logic [8:0]  stored_step_speed;
		logic [15:0] pulse_minimum;
		logic [15:0] pulse_maximum;
		logic [8:0]  default_step_speed;
		logic [7:0]  stopping_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] key_code;
		logic [1:0] trigger_line;
		logic       trigger_level;
	} item_t;

	typedef struct packed {
		logic [15:0] pulse_width;
		logic [15:0] target_position;
		logic [1:0]  mode;
		logic        led_on;
		logic        servo_power;
		logic        pwm_running;
	} res_t;

	// Product of speed (<512) and soft-start (<=100) divided by 100
	function automatic logic [8:0] div100(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(RECIP_100);
		return p[RECIP_SHIFT+8:RECIP_SHIFT];
	endfunction

endpackage

`default_nettype wire

[rtl/srsc_in_if.sv]
`default_nettype none

interface srsc_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [2:0] key_code;
	logic [1:0] trigger_line;
	logic       trigger_level;

	modport source (output valid, action, key_code, trigger_line, trigger_level,
		input ready);
	modport sink (input valid, action, key_code, trigger_line, trigger_level,
		output ready);
endinterface

`default_nettype wire

[rtl/srsc_out_if.sv]
`default_nettype none

interface srsc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pulse_width;
	logic [15:0] target_position;
	logic [1:0]  mode;
	logic        led_on;
	logic        servo_power;
	logic        pwm_running;

	modport source (output valid, pulse_width, target_position, mode, led_on,
		servo_power, pwm_running, input ready);
	modport sink (input valid, pulse_width, target_position, mode, led_on,
		servo_power, pwm_running, output ready);
endinterface

`default_nettype wire

[rtl/srsc_cfg_regs.sv]
`default_nettype none

module srsc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [srsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output srsc_pkg::cfg_t                        cfg
);

	srsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stored_valid           <= 1'b0;
			cfg_q.stored_first_position  <= 16'd32000;
			cfg_q.stored_second_position <= 16'd32000;
			cfg_q.stored_step_speed      <= 9'd16;
			cfg_q.pulse_minimum          <= 16'd8000;
			cfg_q.pulse_maximum          <= 16'd43200;
			cfg_q.default_step_speed     <= 9'd16;
			cfg_q.stopping_ticks         <= 8'd25;
		end else if (cfg_we) begin
			case (cfg_index)
				srsc_pkg::CFG_STORED_VALID:  cfg_q.stored_valid <= cfg_data[0];
				srsc_pkg::CFG_STORED_FIRST:  cfg_q.stored_first_position <= cfg_data;
				srsc_pkg::CFG_STORED_SECOND: cfg_q.stored_second_position <= cfg_data;
				srsc_pkg::CFG_STORED_SPEED:  cfg_q.stored_step_speed <= cfg_data[8:0];
				srsc_pkg::CFG_PULSE_MIN:     cfg_q.pulse_minimum <= cfg_data;
				srsc_pkg::CFG_PULSE_MAX:     cfg_q.pulse_maximum <= cfg_data;
				srsc_pkg::CFG_DEFAULT_SPEED: cfg_q.default_step_speed <= cfg_data[8:0];
				srsc_pkg::CFG_STOP_TICKS:    cfg_q.stopping_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/srsc_core.sv]
`default_nettype none

module srsc_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  srsc_pkg::item_t item,
	input  srsc_pkg::cfg_t  cfg,
	output srsc_pkg::res_t  res
);

	logic [1:0]        mode_q;
	logic [15:0]       target_q, pulse_q, first_q, second_q;
	logic [8:0]        speed_q;
	logic              sweep_up_q, active_q, led_q, power_q;
	logic signed [7:0] soft_q;
	logic [7:0]        stop_q;
	logic [3:0]        tick_low_q, blink_q;
	logic [15:0]       saved_first_q, saved_second_q;
	logic [8:0]        saved_speed_q;
	logic [15:0]       tick_prod_q;   // speed * soft-start value of the next tick

	logic [1:0]        n_mode;
	logic [15:0]       n_target, n_pulse, n_first, n_second;
	logic [8:0]        n_speed;
	logic              n_sweep_up, n_active, n_led, n_power;
	logic signed [7:0] n_soft;
	logic [7:0]        n_stop;
	logic [3:0]        n_tick_low, n_blink;
	logic [15:0]       n_saved_first, n_saved_second;
	logic [8:0]        n_saved_speed;
	logic [15:0]       n_tick_prod;

	logic [16:0] mid_sum;
	logic [15:0] mid;
	logic [4:0]  blink_lim;
	logic [3:0]  blink_nx;
	logic [15:0] hi, lo, step;
	logic [16:0] sum17, bound17;
	logic signed [7:0] soft_m0;
	logic [6:0]  soft_clamp;

	always_comb begin
		n_mode = mode_q; n_target = target_q; n_pulse = pulse_q;
		n_first = first_q; n_second = second_q; n_speed = speed_q;
		n_sweep_up = sweep_up_q; n_active = active_q; n_led = led_q; n_power = power_q;
		n_soft = soft_q; n_stop = stop_q; n_tick_low = tick_low_q; n_blink = blink_q;
		n_saved_first = saved_first_q; n_saved_second = saved_second_q;
		n_saved_speed = saved_speed_q;

		mid_sum   = {1'b0, cfg.pulse_minimum} + {1'b0, cfg.pulse_maximum};
		mid       = mid_sum[16:1];
		blink_lim = {2'b00, mode_q, 1'b0};
		blink_nx  = blink_q + 4'd1;
		hi        = (second_q > first_q) ? second_q : first_q;
		lo        = (second_q < first_q) ? second_q : first_q;
		step      = 16'd0;
		sum17     = 17'd0;
		bound17   = 17'd0;

		case (item.action)
			srsc_pkg::ACT_START: begin
				n_sweep_up = 1'b0; n_led = 1'b0; n_power = 1'b0;
				n_tick_low = '0; n_blink = '0;
				n_saved_first  = cfg.stored_first_position;
				n_saved_second = cfg.stored_second_position;
				n_saved_speed  = cfg.stored_step_speed;
				if (cfg.stored_valid) begin
					n_first  = cfg.stored_first_position;
					n_second = cfg.stored_second_position;
					n_speed  = cfg.stored_step_speed;
					n_target = cfg.stored_first_position;
					n_mode   = srsc_pkg::MODE_OPER;
					n_stop   = srsc_pkg::STOP_TICKS_VALID;
				end else begin
					n_first  = mid;
					n_second = mid;
					n_target = mid;
					n_speed  = cfg.default_step_speed;
					n_mode   = srsc_pkg::MODE_POS1;
					n_stop   = cfg.stopping_ticks;
				end
				n_pulse  = n_target;
				n_active = 1'b1;
				n_soft   = srsc_pkg::SOFT_INIT;
			end

			srsc_pkg::ACT_TICK: begin
				n_tick_low = (tick_low_q + 4'd1) & srsc_pkg::TICK_MASK;
				if (mode_q != srsc_pkg::MODE_OPER && n_tick_low == 4'd0) begin
					n_blink = blink_nx;
					if ({1'b0, blink_nx} < blink_lim + 5'd1)
						n_led = blink_nx[0];
					else if ({1'b0, blink_nx} > blink_lim + 5'd3)
						n_blink = 4'd0;
				end

				// Speed setup: the target sweeps between the two end positions
				if (mode_q == srsc_pkg::MODE_SPEED) begin
					if (sweep_up_q) begin
						sum17 = {1'b0, target_q} + 17'(speed_q);
						if (sum17 > {1'b0, hi}) begin
							n_target   = hi;
							n_sweep_up = 1'b0;
						end else begin
							n_target = sum17[15:0];
						end
					end else begin
						bound17 = {1'b0, lo} + 17'(speed_q);
						if ({1'b0, target_q} < bound17) begin
							n_target   = lo;
							n_sweep_up = 1'b1;
						end else begin
							n_target = target_q - 16'(speed_q);
						end
					end
					n_soft = srsc_pkg::SOFT_FULL;
				end else if (mode_q == srsc_pkg::MODE_OPER) begin
					if (soft_q < srsc_pkg::SOFT_FULL)
						n_soft = soft_q + 8'sd1;
				end else begin
					n_soft = srsc_pkg::SOFT_FULL;
				end

				// Outside operation soft start is full, so the step is the speed
				if (mode_q == srsc_pkg::MODE_OPER)
					step = 16'(srsc_pkg::div100(tick_prod_q));
				else
					step = 16'(speed_q);

				if (n_soft > 8'sd0) begin
					n_power = 1'b1;
					if (pulse_q < n_target) begin
						sum17 = {1'b0, pulse_q} + {1'b0, step};
						n_pulse = (sum17 > {1'b0, n_target}) ? n_target : sum17[15:0];
					end else if (pulse_q > n_target) begin
						bound17 = {1'b0, n_target} + {1'b0, step};
						n_pulse = ({1'b0, pulse_q} < bound17) ? n_target : pulse_q - step;
					end else if (mode_q == srsc_pkg::MODE_OPER) begin
						if (stop_q <= 8'd1) begin
							n_stop   = 8'd0;
							n_active = 1'b0;
							n_power  = 1'b0;
						end else begin
							n_stop = stop_q - 8'd1;
						end
					end
				end
			end

			srsc_pkg::ACT_KEY: begin
				if (!active_q) begin
					n_active = 1'b1;
					n_soft   = srsc_pkg::SOFT_INIT;
					n_stop   = cfg.stopping_ticks;
				end
				case (item.key_code)
					srsc_pkg::KEY_S1_PRESS, srsc_pkg::KEY_S1_REPEAT: begin
						if (mode_q == srsc_pkg::MODE_OPER) begin
							if (item.key_code == srsc_pkg::KEY_S1_PRESS)
								n_target = second_q;
						end else if (mode_q == srsc_pkg::MODE_SPEED) begin
							n_speed = (speed_q >= srsc_pkg::SPEED_MAX) ?
								srsc_pkg::SPEED_MAX : speed_q + 9'd1;
						end else begin
							sum17 = {1'b0, target_q} + 17'(speed_q);
							n_target = (sum17 > {1'b0, cfg.pulse_maximum}) ?
								cfg.pulse_maximum : sum17[15:0];
						end
					end
					srsc_pkg::KEY_S2_PRESS, srsc_pkg::KEY_S2_REPEAT: begin
						if (mode_q == srsc_pkg::MODE_OPER) begin
							if (item.key_code == srsc_pkg::KEY_S2_PRESS)
								n_target = first_q;
						end else if (mode_q == srsc_pkg::MODE_SPEED) begin
							n_speed = (speed_q <= srsc_pkg::SPEED_MIN) ?
								srsc_pkg::SPEED_MIN : speed_q - 9'd1;
						end else begin
							bound17 = {1'b0, cfg.pulse_minimum} + 17'(speed_q);
							n_target = ({1'b0, target_q} < bound17) ?
								cfg.pulse_minimum : target_q - 16'(speed_q);
						end
					end
					srsc_pkg::KEY_S3_PRESS: begin
						case (mode_q)
							srsc_pkg::MODE_OPER: begin
								n_mode  = srsc_pkg::MODE_POS1;
								n_speed = cfg.default_step_speed;
							end
							srsc_pkg::MODE_POS1: begin
								n_first = target_q;
								n_mode  = srsc_pkg::MODE_POS2;
							end
							srsc_pkg::MODE_POS2: begin
								n_second   = target_q;
								n_sweep_up = 1'b0;
								n_mode     = srsc_pkg::MODE_SPEED;
							end
							default: begin
								// leaving setup saves the settings
								n_mode         = srsc_pkg::MODE_OPER;
								n_saved_first  = first_q;
								n_saved_second = second_q;
								n_saved_speed  = speed_q;
								n_led          = 1'b0;
								n_target       = first_q;
							end
						endcase
					end
					default: ;
				endcase
			end

			srsc_pkg::ACT_TRIGGER: begin
				if (mode_q == srsc_pkg::MODE_OPER && !item.trigger_level) begin
					if (item.trigger_line == srsc_pkg::LINE_FIRST)
						n_target = first_q;
					else if (item.trigger_line == srsc_pkg::LINE_SECOND)
						n_target = second_q;
					if (!active_q) begin
						n_active = 1'b1;
						n_soft   = srsc_pkg::SOFT_INIT;
						n_stop   = cfg.stopping_ticks;
					end
				end
			end

			srsc_pkg::ACT_TIMEOUT: begin
				if (mode_q != srsc_pkg::MODE_OPER && cfg.stored_valid) begin
					n_first  = saved_first_q;
					n_second = saved_second_q;
					n_speed  = saved_speed_q;
					n_mode   = srsc_pkg::MODE_OPER;
					n_led    = 1'b0;
				end
			end

			default: ;
		endcase
	end

	// Soft-start value the next tick in operation will use, clamped at zero
	always_comb begin
		soft_m0 = (n_soft < srsc_pkg::SOFT_FULL) ? n_soft + 8'sd1 : n_soft;
		soft_clamp = (soft_m0 > 8'sd0) ? soft_m0[6:0] : 7'd0;
		n_tick_prod = 16'(n_speed * soft_clamp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= srsc_pkg::MODE_POS1;
			target_q <= '0; pulse_q <= '0; first_q <= '0; second_q <= '0;
			speed_q <= '0; sweep_up_q <= 1'b0; active_q <= 1'b0;
			led_q <= 1'b0; power_q <= 1'b0; soft_q <= '0; stop_q <= '0;
			tick_low_q <= '0; blink_q <= '0;
			saved_first_q <= '0; saved_second_q <= '0; saved_speed_q <= '0;
			tick_prod_q <= '0;
		end else if (adv) begin
			mode_q <= n_mode;
			target_q <= n_target; pulse_q <= n_pulse;
			first_q <= n_first; second_q <= n_second;
			speed_q <= n_speed; sweep_up_q <= n_sweep_up; active_q <= n_active;
			led_q <= n_led; power_q <= n_power; soft_q <= n_soft; stop_q <= n_stop;
			tick_low_q <= n_tick_low; blink_q <= n_blink;
			saved_first_q <= n_saved_first; saved_second_q <= n_saved_second;
			saved_speed_q <= n_saved_speed;
			tick_prod_q <= n_tick_prod;
		end
	end

	assign res.pulse_width     = n_pulse;
	assign res.target_position = n_target;
	assign res.mode            = n_mode;
	assign res.led_on          = n_led;
	assign res.servo_power     = n_power;
	assign res.pwm_running     = n_active;

	// Any key enables the ramp
	a_key_enables: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.action == srsc_pkg::ACT_KEY |=> active_q)
		else $error("key did not enable the ramp");

	// Start with valid settings goes straight to operation
	a_valid_start: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.action == srsc_pkg::ACT_START && cfg.stored_valid |=>
		mode_q == srsc_pkg::MODE_OPER && active_q &&
		stop_q == srsc_pkg::STOP_TICKS_VALID && pulse_q == target_q)
		else $error("start with valid settings misbehaved");

	// The ramp never overshoots a fixed target
	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.action == srsc_pkg::ACT_TICK && mode_q != srsc_pkg::MODE_SPEED &&
		pulse_q < target_q |=> pulse_q <= target_q)
		else $error("pulse ramp overshot target");

	// Timeout with valid settings drops back to operation with LED off
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.action == srsc_pkg::ACT_TIMEOUT && cfg.stored_valid |=>
		mode_q == srsc_pkg::MODE_OPER && !led_q)
		else $error("timeout did not restore operation");

endmodule

`default_nettype wire

[rtl/servo_ramp_setup_controller.sv]
// Servo ramp and setup controller.
//
// evt channel: one item per event (start, 20 ms tick, key, trigger edge,
// inactivity timeout). res channel: one item per event, showing pulse
// width, target, mode, LED, servo power and ramp-active after that event.
// cfg port: cfg_we writes cfg_data into register cfg_index;
// write only while no event is in flight.
//
// An accepted event sits in an input register; once the result register can
// take it, the event runs through the state update and loads the result
// register. One event per cycle is taken for as long as the result side
// keeps up; the limit is the single state update per cycle, whose longest
// path is the product register, the divide-by-100 reciprocal multiply and
// the ramp add and clamp. When res stalls, the result register holds and
// the input register fills, after which evt.ready drops; nothing is lost.
// Reset empties both registers, sets mode to position-one setup and clears
// the ramp state; the configuration returns to its defaults.
`default_nettype none

module servo_ramp_setup_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	srsc_in_if.sink                               evt,
	srsc_out_if.source                            res,
	input  wire logic                             cfg_we,
	input  wire logic [srsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [srsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	srsc_pkg::cfg_t  cfg;
	srsc_pkg::item_t item_s1;
	logic            valid_s1;
	srsc_pkg::res_t  core_res;
	srsc_pkg::res_t  res_q;
	logic            res_valid_q;
	logic            adv;

	srsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held event is processed whenever the result register can take it
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.action        <= evt.action;
			item_s1.key_code      <= evt.key_code;
			item_s1.trigger_line  <= evt.trigger_line;
			item_s1.trigger_level <= evt.trigger_level;
		end
	end

	srsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= core_res;
	end

	assign res.valid           = res_valid_q;
	assign res.pulse_width     = res_q.pulse_width;
	assign res.target_position = res_q.target_position;
	assign res.mode            = res_q.mode;
	assign res.led_on          = res_q.led_on;
	assign res.servo_power     = res_q.servo_power;
	assign res.pwm_running     = res_q.pwm_running;

endmodule

`default_nettype wire
